>>> design/ilha_pkg.sv
// Package for the implicit-list heap allocator: constants, codes, state type
// and the structs that run between the sequencer, the shared adder and the RAM.
// Depends on nothing.
package ilha_pkg;

    localparam int HEAP_BYTES_DEF = 65536;
    localparam int WSIZE          = 4;
    localparam int DSIZE          = 8;
    localparam int MIN_BLOCK      = 2 * DSIZE;
    localparam int HEAP_START     = 4 * WSIZE;
    localparam int CHUNK_RESET    = 4096;

    localparam logic [31:0] TAG_EPILOGUE = 32'd1;
    localparam logic [31:0] TAG_PROLOGUE = 32'd9;

    localparam logic [31:0] OFF_ZERO = 32'd0;
    localparam logic [31:0] OFF_M4   = 32'hFFFF_FFFC;
    localparam logic [31:0] OFF_M8   = 32'hFFFF_FFF8;
    localparam logic [31:0] OFF_P15  = 32'd15;
    localparam logic [31:0] OFF_P16  = 32'd16;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_OOM     = 2'd2;

    typedef enum logic [5:0] {
        S_CLR, S_IDLE, S_ASZ,
        S_FF0, S_FF1, S_FF2, S_FF3,
        S_EXT0, S_GR0, S_GR1, S_GR2, S_GR3, S_GR4,
        S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8,
        S_MA1, S_MA2, S_MB1, S_MB2, S_MC1, S_MC2, S_MC3, S_MC4, S_MEND,
        S_PL0, S_PL1, S_PL2, S_PS1, S_PS2, S_PS3, S_PS4, S_PS5, S_PS6,
        S_PN1, S_PN2,
        S_FR0, S_FR1, S_FR2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] off;
        logic        neg;
    } t_alu_req;

    typedef struct packed {
        logic        re;
        logic        we;
        logic [31:0] addr;
        logic [31:0] wdata;
    } t_ram_req;

    typedef struct packed {
        logic        req_type;
        logic [15:0] size_bytes;
        logic [15:0] block_addr;
    } t_req;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [15:0] payload_addr;
    } t_res;

endpackage

>>> design/ilha_ram.sv
// Single-port heap word memory with registered read data.
// Depends on ilha_pkg for the request struct.
module ilha_ram
    import ilha_pkg::*;
#(
    parameter int DEPTH = HEAP_BYTES_DEF / WSIZE
) (
    input  logic        i_clk,
    input  t_ram_req    i_req,
    output logic [31:0] o_rdata
);

    localparam int AW = $clog2(DEPTH);

    logic [31:0]   mem [DEPTH];
    logic [AW-1:0] idx;

    // Byte offsets wrap onto the word array; the depth is a power of two.
    assign idx = i_req.addr[AW+1:2];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[idx] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= mem[idx];
        end
    end

endmodule

>>> design/ilha_alu.sv
// Shared 32-bit adder of the allocator: a plus or minus b plus a small offset.
// Depends on ilha_pkg for the request struct.
module ilha_alu
    import ilha_pkg::*;
(
    input  t_alu_req    i_req,
    output logic [32:0] o_y
);

    logic [31:0] b_op;

    assign b_op = i_req.neg ? ~i_req.b : i_req.b;

    // With a zero offset and neg set, bit 32 is the carry, i.e. a >= b.
    assign o_y = {1'b0, i_req.a} + {1'b0, b_op} + {32'd0, i_req.neg} + {1'b0, i_req.off};

endmodule

>>> design/ilha_seq.sv
// Sequencer of the allocator: clearing pass, first-fit walk, heap growth,
// coalescing and block placement, all through one shared adder and one RAM port.
// Depends on ilha_pkg.
module ilha_seq
    import ilha_pkg::*;
#(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  t_req        i_req,
    output logic        o_ready,
    input  logic [16:0] i_chunk,
    input  logic        i_out_free,
    output t_res        o_res,
    output t_ram_req    o_ram,
    input  logic [31:0] i_ram_rdata,
    output t_alu_req    o_alu,
    input  logic [32:0] i_alu_y
);

    localparam int DEPTH = HEAP_BYTES / WSIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int MAXN  = HEAP_BYTES / DSIZE;
    localparam int CW    = $clog2(MAXN + 1);

    t_state r_state, n_state;

    logic [AW-1:0] r_clr;
    logic [CW-1:0] r_cnt;
    logic          r_init;
    logic          r_type;
    logic [15:0]   r_size;
    logic [31:0]   r_p, r_q, r_n, r_f, r_s, r_sz, r_qs, r_nsz, r_psz;
    logic [31:0]   r_asize, r_ext, r_cs, r_t, r_bp, r_brk;
    logic          r_al, r_pa;
    logic [1:0]    r_st;
    logic [15:0]   r_pay;

    logic [31:0] rd_sz;
    logic        rd_al;
    logic        carry;
    logic        accept;
    logic        ff_stop;
    logic        fit;
    logic        over;
    logic [31:0] init_word;

    assign rd_sz  = i_ram_rdata & ~32'd7;
    assign rd_al  = i_ram_rdata[0];
    assign carry  = i_alu_y[32];
    assign accept = i_req_valid && (r_state == S_IDLE);
    assign ff_stop = (rd_sz == 32'd0) || carry;
    assign fit    = !r_al && carry;
    assign over   = i_alu_y > 33'(HEAP_BYTES);

    always_comb begin
        case (r_clr)
            AW'(1), AW'(2): init_word = TAG_PROLOGUE;
            AW'(3):         init_word = TAG_EPILOGUE;
            default:        init_word = 32'd0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr == AW'(DEPTH - 1)) n_state = S_GR0;
            S_IDLE: begin
                if (accept) begin
                    if (i_req.req_type == REQ_ALLOC) begin
                        n_state = (i_req.size_bytes == 16'd0) ? S_DONE : S_ASZ;
                    end else begin
                        n_state = (i_req.block_addr == 16'd0) ? S_DONE : S_FR0;
                    end
                end
            end
            S_ASZ:  n_state = S_FF0;
            S_FF0:  n_state = S_FF1;
            S_FF1:  n_state = ff_stop ? S_EXT0 : S_FF2;
            S_FF2:  n_state = fit ? S_PL0 : S_FF3;
            S_FF3:  n_state = (r_cnt == CW'(MAXN)) ? S_EXT0 : S_FF0;
            S_EXT0: n_state = S_GR0;
            S_GR0:  n_state = S_GR1;
            S_GR1:  n_state = over ? (r_init ? S_IDLE : S_DONE) : S_GR2;
            S_GR2:  n_state = S_GR3;
            S_GR3:  n_state = S_GR4;
            S_GR4:  n_state = S_M0;
            S_M0:   n_state = S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_M4;
            S_M4:   n_state = S_M5;
            S_M5:   n_state = S_M6;
            S_M6:   n_state = S_M7;
            S_M7:   n_state = S_M8;
            S_M8: begin
                if (r_pa && rd_al)  n_state = S_MEND;
                else if (r_pa)      n_state = S_MA1;
                else if (rd_al)     n_state = S_MB1;
                else                n_state = S_MC1;
            end
            S_MA1:  n_state = S_MA2;
            S_MA2:  n_state = S_MEND;
            S_MB1:  n_state = S_MB2;
            S_MB2:  n_state = S_MEND;
            S_MC1:  n_state = S_MC2;
            S_MC2:  n_state = S_MC3;
            S_MC3:  n_state = S_MC4;
            S_MC4:  n_state = S_MEND;
            S_MEND: begin
                if (r_init)                 n_state = S_IDLE;
                else if (r_type == REQ_FREE) n_state = S_DONE;
                else                        n_state = S_PL0;
            end
            S_PL0:  n_state = S_PL1;
            S_PL1:  n_state = S_PL2;
            S_PL2:  n_state = carry ? S_PS1 : S_PN1;
            S_PS1:  n_state = S_PS2;
            S_PS2:  n_state = S_PS3;
            S_PS3:  n_state = S_PS4;
            S_PS4:  n_state = S_PS5;
            S_PS5:  n_state = S_PS6;
            S_PS6:  n_state = S_DONE;
            S_PN1:  n_state = S_PN2;
            S_PN2:  n_state = S_DONE;
            S_FR0:  n_state = S_FR1;
            S_FR1:  n_state = S_FR2;
            S_FR2:  n_state = S_M0;
            S_DONE: if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Adder operands and memory requests; every memory address but those of the clearing pass comes from the adder.
    always_comb begin
        o_alu       = '{a: 32'd0, b: 32'd0, off: OFF_ZERO, neg: 1'b0};
        o_ram.re    = 1'b0;
        o_ram.we    = 1'b0;
        o_ram.addr  = i_alu_y[31:0];
        o_ram.wdata = r_sz;
        unique case (r_state)
            S_CLR: begin
                o_ram.we    = 1'b1;
                o_ram.addr  = {{(30 - AW){1'b0}}, r_clr, 2'b00};
                o_ram.wdata = init_word;
            end
            S_ASZ:  o_alu = '{a: {16'd0, r_size}, b: 32'd0, off: OFF_P15, neg: 1'b0};
            S_FF0: begin
                o_alu    = '{a: r_p, b: 32'd0, off: OFF_M4, neg: 1'b0};
                o_ram.re = 1'b1;
            end
            S_FF1:  o_alu = '{a: r_p, b: r_brk, off: OFF_ZERO, neg: 1'b1};
            S_FF2:  o_alu = '{a: r_s, b: r_asize, off: OFF_ZERO, neg: 1'b1};
            S_FF3:  o_alu = '{a: r_p, b: r_s, off: OFF_ZERO, neg: 1'b0};
            S_EXT0: o_alu = '{a: {15'd0, i_chunk}, b: r_asize, off: OFF_ZERO, neg: 1'b1};
            S_GR0:  o_alu = '{a: {2'b00, r_ext[31:2]}, b: {31'd0, r_ext[2]},
                              off: OFF_ZERO, neg: 1'b0};
            S_GR1:  o_alu = '{a: r_brk, b: r_sz, off: OFF_ZERO, neg: 1'b0};
            S_GR2: begin
                o_alu    = '{a: r_p, b: 32'd0, off: OFF_M4, neg: 1'b0};
                o_ram.we = 1'b1;
            end
            S_GR3: begin
                o_alu    = '{a: r_p, b: r_sz, off: OFF_M8, neg: 1'b0};
                o_ram.we = 1'b1;
            end
            S_GR4: begin
                o_alu       = '{a: r_p, b: r_sz, off: OFF_M4, neg: 1'b0};
                o_ram.we    = 1'b1;
                o_ram.wdata = TAG_EPILOGUE;
            end
            S_M0: begin
                o_alu    = '{a: r_p, b: 32'd0, off: OFF_M8, neg: 1'b0};
                o_ram.re = 1'b1;
            end
            S_M1:   o_alu = '{a: r_p, b: rd_sz, off: OFF_ZERO, neg: 1'b1};
            S_M2: begin
                o_alu    = '{a: r_q, b: 32'd0, off: OFF_M4, neg: 1'b0};
                o_ram.re = 1'b1;
            end
            S_M3:   o_alu = '{a: r_q, b: rd_sz, off: OFF_M8, neg: 1'b0};
            S_M4: begin
                o_alu    = '{a: r_f, b: 32'd0, off: OFF_ZERO, neg: 1'b0};
                o_ram.re = 1'b1;
            end
            S_M5: begin
                o_alu    = '{a: r_p, b: 32'd0, off: OFF_M4, neg: 1'b0};
                o_ram.re = 1'b1;
            end
            S_M6:   o_alu = '{a: r_p, b: rd_sz, off: OFF_ZERO, neg: 1'b0};
            S_M7: begin
                o_alu    = '{a: r_n, b: 32'd0, off: OFF_M4, neg: 1'b0};
                o_ram.re = 1'b1;
            end
            S_M8: begin
                if (r_pa)       o_alu = '{a: r_psz, b: rd_sz, off: OFF_ZERO, neg: 1'b0};
                else if (rd_al) o_alu = '{a: r_psz, b: r_qs, off: OFF_ZERO, neg: 1'b0};
                else            o_alu = '{a: r_n, b: rd_sz, off: OFF_M8, neg: 1'b0};
            end
            S_MA1: begin
                o_alu    = '{a: r_p, b: 32'd0, off: OFF_M4, neg: 1'b0};
                o_ram.we = 1'b1;
            end
            S_MA2: begin
                o_alu    = '{a: r_p, b: r_sz, off: OFF_M8, neg: 1'b0};
                o_ram.we = 1'b1;
            end
            S_MB1: begin
                o_alu    = '{a: r_p, b: r_psz, off: OFF_M8, neg: 1'b0};
                o_ram.we = 1'b1;
            end
            S_MB2: begin
                o_alu    = '{a: r_q, b: 32'd0, off: OFF_M4, neg: 1'b0};
                o_ram.we = 1'b1;
            end
            S_MC1:  o_alu = '{a: r_psz, b: r_qs, off: OFF_ZERO, neg: 1'b0};
            S_MC2:  o_alu = '{a: r_sz, b: r_nsz, off: OFF_ZERO, neg: 1'b0};
            S_MC3: begin
                o_alu    = '{a: r_q, b: 32'd0, off: OFF_M4, neg: 1'b0};
                o_ram.we = 1'b1;
            end
            S_MC4: begin
                o_alu    = '{a: r_f, b: 32'd0, off: OFF_ZERO, neg: 1'b0};
                o_ram.we = 1'b1;
            end
            S_PL0: begin
                o_alu    = '{a: r_p, b: 32'd0, off: OFF_M4, neg: 1'b0};
                o_ram.re = 1'b1;
            end
            S_PL1:  o_alu = '{a: r_asize, b: 32'd0, off: OFF_P16, neg: 1'b0};
            S_PL2:  o_alu = '{a: r_cs, b: r_t, off: OFF_ZERO, neg: 1'b1};
            S_PS1: begin
                o_alu       = '{a: r_p, b: 32'd0, off: OFF_M4, neg: 1'b0};
                o_ram.we    = 1'b1;
                o_ram.wdata = r_asize | 32'd1;
            end
            S_PS2: begin
                o_alu       = '{a: r_p, b: r_asize, off: OFF_M8, neg: 1'b0};
                o_ram.we    = 1'b1;
                o_ram.wdata = r_asize | 32'd1;
            end
            S_PS3:  o_alu = '{a: r_p, b: r_asize, off: OFF_ZERO, neg: 1'b0};
            S_PS4:  o_alu = '{a: r_cs, b: r_asize, off: OFF_ZERO, neg: 1'b1};
            S_PS5: begin
                o_alu    = '{a: r_q, b: 32'd0, off: OFF_M4, neg: 1'b0};
                o_ram.we = 1'b1;
            end
            S_PS6: begin
                o_alu    = '{a: r_q, b: r_sz, off: OFF_M8, neg: 1'b0};
                o_ram.we = 1'b1;
            end
            S_PN1: begin
                o_alu       = '{a: r_p, b: 32'd0, off: OFF_M4, neg: 1'b0};
                o_ram.we    = 1'b1;
                o_ram.wdata = r_cs | 32'd1;
            end
            S_PN2: begin
                o_alu       = '{a: r_p, b: r_cs, off: OFF_M8, neg: 1'b0};
                o_ram.we    = 1'b1;
                o_ram.wdata = r_cs | 32'd1;
            end
            S_FR0: begin
                o_alu    = '{a: r_p, b: 32'd0, off: OFF_M4, neg: 1'b0};
                o_ram.re = 1'b1;
            end
            S_FR1: begin
                o_alu       = '{a: r_p, b: 32'd0, off: OFF_M4, neg: 1'b0};
                o_ram.we    = 1'b1;
                o_ram.wdata = rd_sz;
            end
            S_FR2: begin
                o_alu    = '{a: r_p, b: r_sz, off: OFF_M8, neg: 1'b0};
                o_ram.we = 1'b1;
            end
            default: o_ram.re = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_init  <= 1'b1;
            r_brk   <= 32'(HEAP_START);
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (r_state == S_MEND || (r_state == S_GR1 && over)) begin
                r_init <= 1'b0;
            end
            if (r_state == S_GR1 && !over) begin
                r_brk <= i_alu_y[31:0];
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_CLR:  r_ext <= 32'(CHUNK_RESET);
            S_IDLE: begin
                r_type <= i_req.req_type;
                r_size <= i_req.size_bytes;
                r_p    <= {16'd0, i_req.block_addr};
                r_pay  <= 16'd0;
                r_st   <= ((i_req.req_type == REQ_ALLOC && i_req.size_bytes == 16'd0) ||
                           (i_req.req_type == REQ_FREE && i_req.block_addr == 16'd0))
                          ? ST_IGNORED : ST_DONE;
            end
            S_ASZ: begin
                r_asize <= (r_size <= 16'(DSIZE)) ? 32'(MIN_BLOCK)
                                                  : (i_alu_y[31:0] & ~32'd7);
                r_p     <= 32'(2 * WSIZE);
                r_cnt   <= '0;
            end
            S_FF1: begin
                r_s  <= rd_sz;
                r_al <= rd_al;
            end
            S_FF2:  r_bp <= r_p;
            S_FF3: begin
                r_p   <= i_alu_y[31:0];
                r_cnt <= r_cnt + CW'(1);
            end
            S_EXT0: r_ext <= carry ? {15'd0, i_chunk} : r_asize;
            S_GR0:  r_sz <= {i_alu_y[29:0], 2'b00};
            S_GR1: begin
                r_p <= r_brk;
                if (over) begin
                    r_st <= ST_OOM;
                end
            end
            S_M1:   r_q <= i_alu_y[31:0];
            S_M3: begin
                r_qs <= rd_sz;
                r_f  <= i_alu_y[31:0];
            end
            S_M5:   r_pa <= rd_al;
            S_M6: begin
                r_psz <= rd_sz;
                r_n   <= i_alu_y[31:0];
            end
            S_M8: begin
                r_nsz <= rd_sz;
                if (r_pa || rd_al) begin
                    r_sz <= i_alu_y[31:0];
                end else begin
                    r_f <= i_alu_y[31:0];
                end
            end
            S_MB2, S_MC4: r_p <= r_q;
            S_MC1, S_MC2: r_sz <= i_alu_y[31:0];
            S_MEND: r_bp <= r_p;
            S_PL1: begin
                r_cs <= rd_sz;
                r_t  <= i_alu_y[31:0];
            end
            S_PS3:  r_q <= i_alu_y[31:0];
            S_PS4:  r_sz <= i_alu_y[31:0];
            S_PS6, S_PN2: r_pay <= r_bp[15:0];
            S_FR1:  r_sz <= rd_sz;
            default: r_t <= r_t;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_res   = '{valid: (r_state == S_DONE), status: r_st, payload_addr: r_pay};

endmodule

>>> design/implicit_list_heap_allocator_unit.sv
// Heap allocator, first fit over an implicit block list with boundary tags.
// A free request merges the freed block with free neighbours. An allocate request walks the
// list and places the block in the first free block that fits, whole or split; if nothing fits,
// the heap grows and merges first. One request at a time through one RAM port and one adder.
// Reset (synchronous, active low) runs a clearing pass over every heap word and then lays
// out the first chunk; requests are not taken meanwhile.
module implicit_list_heap_allocator_unit
    import ilha_pkg::*;
#(
    // Heap size in bytes; a power of two.
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,     // chunk_bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // [15:0] size_bytes, [31:16] block_addr
    input  logic        s_axis_tuser,    // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata     // [1:0] status, [17:2] payload_addr, rest zero
);

    localparam int DEPTH = HEAP_BYTES / WSIZE;

    logic [16:0] r_chunk;
    logic        r_mvalid;
    logic [1:0]  r_mstatus;
    logic [15:0] r_maddr;

    t_req        req;
    t_res        res;
    t_ram_req    ram_req;
    t_alu_req    alu_req;
    logic [31:0] ram_rdata;
    logic [32:0] alu_y;
    logic        out_free;
    logic        seq_ready;

    // The chunk size register is written directly; it is only read when the heap grows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= 17'(CHUNK_RESET);
        end else if (i_cfg_we) begin
            r_chunk <= i_cfg_wdata;
        end
    end

    assign req = '{req_type: s_axis_tuser, size_bytes: s_axis_tdata[15:0],
                   block_addr: s_axis_tdata[31:16]};

    // The result slot is free when empty or being drained this cycle.
    assign out_free = !r_mvalid || m_axis_tready;

    ilha_seq #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req       (req),
        .o_ready     (seq_ready),
        .i_chunk     (r_chunk),
        .i_out_free  (out_free),
        .o_res       (res),
        .o_ram       (ram_req),
        .i_ram_rdata (ram_rdata),
        .o_alu       (alu_req),
        .i_alu_y     (alu_y)
    );

    ilha_alu u_alu (
        .i_req (alu_req),
        .o_y   (alu_y)
    );

    ilha_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    // Output register: the sequencer hands its result over when the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (res.valid && out_free) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && out_free) begin
            r_mstatus <= res.status;
            r_maddr   <= res.payload_addr;
        end
    end

    assign s_axis_tready = seq_ready;
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = {6'd0, r_maddr, r_mstatus};

endmodule

>>> design/ilha_chk.sv
// Port-level checker for the heap allocator, bound to the top level.
// Depends on ilha_pkg for the status codes.
module ilha_chk
    import ilha_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [16:0] i_cfg_wdata,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // The clearing pass keeps requests out right after reset.
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("request taken during the clearing pass");

    // One request at a time: a taken request makes the block busy.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Only successful requests return an address.
    a_addr_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_DONE |-> m_axis_tdata[17:2] == 16'd0)
        else $error("address returned with failing status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] == ST_DONE || m_axis_tdata[1:0] == ST_IGNORED ||
                          m_axis_tdata[1:0] == ST_OOM)
        else $error("undefined status code");

endmodule

bind implicit_list_heap_allocator_unit ilha_chk u_chk (.*);
